// ===== sv/ismu_pkg.sv =====
// Shared types and constants for the Ising Metropolis site update block.
package ismu_pkg;

    localparam int EDGE_DEFAULT = 64;
    localparam int EDGE_MAX     = 256;
    localparam int COORD_W      = $clog2(EDGE_MAX);
    localparam int IN_COORD_W   = 6;
    localparam int RAND_W       = 16;
    localparam int THR_W        = 17;
    localparam int DE_W         = 5;
    localparam int CFG_IDX_W    = 1;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(65536);

    localparam logic [CFG_IDX_W-1:0] CFG_THR_FOUR  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_EIGHT = 1'b1;

    // item kinds
    localparam logic KIND_UPDATE = 1'b0;
    localparam logic KIND_LOAD   = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               prop;
        logic [RAND_W-1:0]  rand_u;
    } ismu_cmd_t;

    typedef struct packed {
        logic                   site_spin;
        logic                   accepted;
        logic signed [DE_W-1:0] energy_change;
    } ismu_res_t;

endpackage

// ===== sv/ismu_ram.sv =====
// Generic single write, single read RAM with registered read data.
module ismu_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/ismu_front.sv =====
// Front end: accepts items, wraps coordinates onto the lattice, two-entry command queue.
module ismu_front #(
    parameter int EDGE = ismu_pkg::EDGE_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [31:0]         s_tdata,   // row[5:0], col[11:6], proposed_spin[12], rand_u[28:13]
    input  logic                s_tuser,   // kind
    output logic                cmd_valid,
    output ismu_pkg::ismu_cmd_t cmd,
    input  logic                cmd_pop
);
    import ismu_pkg::*;

    localparam int ADDR_W  = $clog2(EDGE);
    localparam int TAB_LEN = 1 << IN_COORD_W;

    // coordinate modulo EDGE, a constant table
    logic [ADDR_W-1:0] mod_tab [TAB_LEN];

    for (genvar i = 0; i < TAB_LEN; i++) begin : g_mod
        assign mod_tab[i] = ADDR_W'(i % EDGE);
    end

    ismu_cmd_t q_mem_reg [2];
    logic      wr_ptr_reg;
    logic      rd_ptr_reg;
    logic [1:0] cnt_reg;

    ismu_cmd_t in_cmd;
    logic      push;

    always_comb begin
        in_cmd.kind   = s_tuser;
        in_cmd.row    = COORD_W'(mod_tab[s_tdata[IN_COORD_W-1:0]]);
        in_cmd.col    = COORD_W'(mod_tab[s_tdata[2*IN_COORD_W-1:IN_COORD_W]]);
        in_cmd.prop   = s_tdata[2*IN_COORD_W];
        in_cmd.rand_u = s_tdata[2*IN_COORD_W+RAND_W:2*IN_COORD_W+1];
    end

    assign s_tready  = (cnt_reg != 2'd2);
    assign push      = s_tvalid && s_tready;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                q_mem_reg[wr_ptr_reg] <= in_cmd;
                wr_ptr_reg            <= ~wr_ptr_reg;
            end
            if (cmd_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, cmd_pop})
                2'b10:   cnt_reg <= cnt_reg + 2'd1;
                2'b01:   cnt_reg <= cnt_reg - 2'd1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

// ===== sv/ismu_back.sv =====
// Back end: reads three rows (one on a load), decides the move, writes back, holds the result.
module ismu_back #(
    parameter int EDGE = ismu_pkg::EDGE_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cmd_valid,
    input  ismu_pkg::ismu_cmd_t        cmd,
    output logic                       cmd_pop,
    input  logic [ismu_pkg::THR_W-1:0] thr_four,
    input  logic [ismu_pkg::THR_W-1:0] thr_eight,
    output logic                       res_valid,
    input  logic                       res_ready,
    output ismu_pkg::ismu_res_t        res
);
    import ismu_pkg::*;

    localparam int ADDR_W = $clog2(EDGE);

    typedef enum logic [1:0] {S_IDLE, S_UP, S_DOWN, S_HERE} state_t;

    function automatic logic [ADDR_W-1:0] wrap_dec(input logic [ADDR_W-1:0] v);
        return (v == '0) ? ADDR_W'(EDGE - 1) : v - 1'b1;
    endfunction

    function automatic logic [ADDR_W-1:0] wrap_inc(input logic [ADDR_W-1:0] v);
        return (v == ADDR_W'(EDGE - 1)) ? '0 : v + 1'b1;
    endfunction

    state_t            state_reg, state_next;
    logic              kind_reg;
    logic              prop_reg;
    logic [ADDR_W-1:0] row_reg;
    logic [ADDR_W-1:0] col_reg;
    logic [RAND_W-1:0] rand_reg;
    logic              up_bit_reg;
    logic              dn_bit_reg;
    logic [EDGE-1:0]   row_valid_reg;
    logic              rd_valid_reg;
    logic              fwd_hit_reg;
    logic [EDGE-1:0]   fwd_row_reg;
    logic              res_valid_reg;
    ismu_res_t         res_reg;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [EDGE-1:0]   ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [EDGE-1:0]   ram_rdata;

    logic              out_free;
    logic              finish;
    logic              take;
    logic [ADDR_W-1:0] cmd_row;
    logic [EDGE-1:0]   row_eff;
    logic              here_bit;
    logic              lf_bit;
    logic              rt_bit;
    logic [2:0]        plus;
    logic signed [5:0] de_up;
    logic signed [5:0] de6;
    logic [THR_W-1:0]  thr;
    logic              acc;
    logic              new_bit;
    ismu_res_t         res_next;

    ismu_ram #(
        .WIDTH (EDGE),
        .DEPTH (EDGE)
    ) u_lattice (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free = !res_valid_reg || res_ready;
    assign finish   = (state_reg == S_HERE) && out_free;
    assign take     = cmd_valid && ((state_reg == S_IDLE) || finish);
    assign cmd_pop  = take;
    assign cmd_row  = cmd.row[ADDR_W-1:0];

    // a row written in the cycle it was addressed is taken from the bypass;
    // a row never written holds its reset value of all +1
    assign row_eff  = fwd_hit_reg ? fwd_row_reg : (rd_valid_reg ? ram_rdata : '1);
    assign here_bit = row_eff[col_reg];
    assign lf_bit   = row_eff[wrap_dec(col_reg)];
    assign rt_bit   = row_eff[wrap_inc(col_reg)];

    always_comb begin
        if (take) begin
            ram_raddr = (cmd.kind == KIND_LOAD) ? cmd_row : wrap_dec(cmd_row);
        end else begin
            case (state_reg)
                S_UP:    ram_raddr = wrap_inc(row_reg);
                default: ram_raddr = row_reg;
            endcase
        end
    end

    always_comb begin
        case (state_reg)
            S_IDLE:  state_next = take ? ((cmd.kind == KIND_LOAD) ? S_HERE : S_UP) : S_IDLE;
            S_UP:    state_next = S_DOWN;
            S_DOWN:  state_next = S_HERE;
            S_HERE: begin
                if (!finish) begin
                    state_next = S_HERE;
                end else if (take) begin
                    state_next = (cmd.kind == KIND_LOAD) ? S_HERE : S_UP;
                end else begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // energy change: 2*(sum of neighbors) = 4*plus - 8, sign set by the flip direction
    always_comb begin
        plus  = 3'(up_bit_reg) + 3'(dn_bit_reg) + 3'(lf_bit) + 3'(rt_bit);
        de_up = $signed({1'b0, plus, 2'b00}) - 6'sd8;
        thr   = thr_four;
        if (kind_reg == KIND_LOAD || prop_reg == here_bit) begin
            de6 = '0;
            acc = 1'b1;
        end else begin
            de6 = prop_reg ? -de_up : de_up;
            thr = (de6 == 6'sd8) ? thr_eight : thr_four;
            acc = (de6 > 6'sd0) ? ({1'b0, rand_reg} <= thr) : 1'b1;
        end
        new_bit                = acc ? prop_reg : here_bit;
        res_next.site_spin     = new_bit;
        res_next.accepted      = acc;
        res_next.energy_change = de6[DE_W-1:0];
        ram_wdata              = row_eff;
        ram_wdata[col_reg]     = new_bit;
    end

    assign ram_we    = finish;
    assign ram_waddr = row_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
            row_valid_reg <= '0;
            fwd_hit_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_valid_reg <= row_valid_reg[ram_raddr];
            fwd_hit_reg  <= ram_we && (ram_waddr == ram_raddr);
            fwd_row_reg  <= ram_wdata;
            if (take) begin
                kind_reg <= cmd.kind;
                prop_reg <= cmd.prop;
                row_reg  <= cmd_row;
                col_reg  <= cmd.col[ADDR_W-1:0];
                rand_reg <= cmd.rand_u;
            end
            if (state_reg == S_UP) begin
                up_bit_reg <= here_bit;
            end
            if (state_reg == S_DOWN) begin
                dn_bit_reg <= here_bit;
            end
            if (finish) begin
                row_valid_reg[row_reg] <= 1'b1;
                res_valid_reg          <= 1'b1;
                res_reg                <= res_next;
            end else if (res_ready) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== sv/ising_metropolis_site_update.sv =====
// Metropolis site update on a periodic square Ising lattice, one row-wide lattice RAM.
// An update reads three rows (above, below, same row) in turn on the lattice RAM's single
// read port; a load reads one row. A new item is taken only while idle or as the previous one finishes.
// Input items pass through the two-entry command queue and the back end states into a result register.
// Reset: thresholds go to 65536, row valid flags clear so every site reads +1; no clearing pass.
module ising_metropolis_site_update #(
    parameter int EDGE = ismu_pkg::EDGE_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [31:0]                    s_tdata,   // row[5:0], col[11:6], proposed_spin[12], rand_u[28:13]
    input  logic                           s_tuser,   // kind
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,   // site_spin[0], accepted[1], energy_change[6:2]
    input  logic                           cfg_we,
    input  logic [ismu_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [ismu_pkg::THR_W-1:0]     cfg_wdata
);
    import ismu_pkg::*;

    logic [THR_W-1:0] thr_four_reg;
    logic [THR_W-1:0] thr_eight_reg;
    logic             cmd_valid;
    ismu_cmd_t        cmd;
    logic             cmd_pop;
    ismu_res_t        res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_four_reg  <= THR_RESET;
            thr_eight_reg <= THR_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_THR_FOUR:  thr_four_reg  <= cfg_wdata;
                CFG_THR_EIGHT: thr_eight_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    ismu_front #(
        .EDGE (EDGE)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    ismu_back #(
        .EDGE (EDGE)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .thr_four  (thr_four_reg),
        .thr_eight (thr_eight_reg),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {1'b0, res.energy_change, res.accepted, res.site_spin};

    // energy change is always a multiple of four in [-8, 8]
    a_de_values: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[6:2] == 5'b11000 || m_tdata[6:2] == 5'b11100 ||
                      m_tdata[6:2] == 5'b00000 || m_tdata[6:2] == 5'b00100 ||
                      m_tdata[6:2] == 5'b01000))
        else $error("energy change out of set");

    // a rejected move must have had a positive energy change
    a_reject_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[1]) |-> (m_tdata[6:2] == 5'b00100 || m_tdata[6:2] == 5'b01000))
        else $error("rejection without positive energy change");

    // queue never takes a pop when empty
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_pop |-> cmd_valid)
        else $error("command queue underflow");

endmodule
